### rtl/cpfe_pkg.sv
package cpfe_pkg;

  // Value kinds carried in value_kind
  typedef enum logic [1:0] {
    KIND_FLOAT32 = 2'd0,
    KIND_INT32   = 2'd1,
    KIND_BOOL    = 2'd2,
    KIND_UNSUPP  = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PUB_CHANNEL_MASK = 1'd0,
    REG_DEVICE_ID        = 1'd1
  } cfg_reg_t;
  localparam int unsigned CFG_DATA_W = 16;

  // Frame id fields
  localparam logic [2:0] PRIO_FIELD = 3'd6;
  localparam logic [1:0] PUB_BITS   = 2'b11;

  // Payload codes
  localparam logic [7:0] CODE_POSINT  = 8'd6;
  localparam logic [7:0] CODE_NEGINT  = 8'd7;
  localparam logic [7:0] CODE_FLOAT   = 8'd30;
  localparam logic [7:0] CODE_DECFRAC = 8'd36;
  localparam logic [7:0] CODE_FALSE   = 8'd60;
  localparam logic [7:0] CODE_TRUE    = 8'd61;
  localparam logic [7:0] ARRAY_TWO    = 8'h82;
  localparam logic [7:0] POS_U32_HDR  = 8'h1a;
  localparam logic [7:0] NEG_U32_HDR  = 8'h3a;
  localparam logic [7:0] NEG_SMALL    = 8'h20;

  // Exponent byte range
  localparam logic signed [7:0] EXP_MAX = 8'sd23;
  localparam logic signed [7:0] EXP_MIN = -8'sd23;

  // Payload lengths
  localparam logic [3:0] LEN_BOOL  = 4'd1;
  localparam logic [3:0] LEN_WORD  = 4'd5;
  localparam logic [3:0] LEN_FRAC  = 4'd8;

  typedef struct packed {
    logic [15:0]       node_id;
    logic [15:0]       node_channels;
    kind_t             value_kind;
    logic signed [7:0] exponent;
    logic [31:0]       value_bits;
  } node_t;

  typedef struct packed {
    logic [28:0] frame_id;
    logic [63:0] payload;
    logic [3:0]  payload_len;
    logic        exponent_invalid;
  } frame_t;

  typedef struct packed {
    logic [15:0] pub_channel_mask;
    logic [7:0]  device_id;
  } cfg_t;

endpackage

### rtl/cpfe_if.sv
interface cpfe_node_if;
  logic              valid;
  logic              ready;
  logic [15:0]       node_id;
  logic [15:0]       node_channels;
  logic [1:0]        value_kind;
  logic signed [7:0] exponent;
  logic [31:0]       value_bits;

  modport source (output valid, node_id, node_channels, value_kind, exponent, value_bits,
                  input ready);
  modport sink   (input valid, node_id, node_channels, value_kind, exponent, value_bits,
                  output ready);
endinterface

interface cpfe_frame_if;
  logic        valid;
  logic        ready;
  logic [28:0] frame_id;
  logic [63:0] payload;
  logic [3:0]  payload_len;
  logic        exponent_invalid;

  modport source (output valid, frame_id, payload, payload_len, exponent_invalid,
                  input ready);
  modport sink   (input valid, frame_id, payload, payload_len, exponent_invalid,
                  output ready);
endinterface

interface cpfe_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/cpfe_cfg_regs.sv
module cpfe_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  cpfe_cfg_if.sink      cfg,
  output cpfe_pkg::cfg_t regs
);
  import cpfe_pkg::*;

  cfg_t regs_q;

  assign cfg.ready = 1'b1;
  assign regs      = regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_PUB_CHANNEL_MASK: regs_q.pub_channel_mask <= cfg.data;
        REG_DEVICE_ID:        regs_q.device_id <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/cpfe_encode.sv
module cpfe_encode (
  input  cpfe_pkg::node_t  node,
  input  cpfe_pkg::cfg_t   regs,
  output logic             hit,
  output cpfe_pkg::frame_t frame
);
  import cpfe_pkg::*;

  logic        neg;
  logic [31:0] mag;
  logic [7:0]  exp_byte;
  logic        exp_bad;

  assign neg = node.value_bits[31];
  // CBOR negative integers carry -1-value, which is the bitwise inverse
  assign mag = neg ? ~node.value_bits : node.value_bits;

  always_comb begin
    exp_bad  = 1'b0;
    exp_byte = '0;
    if (node.exponent > 8'sd0 && node.exponent <= EXP_MAX) begin
      exp_byte = node.exponent;
    end else if (node.exponent < 8'sd0 && node.exponent >= EXP_MIN) begin
      exp_byte = (~node.exponent) | NEG_SMALL;
    end else begin
      exp_bad = 1'b1;
    end
  end

  assign hit = (|(node.node_channels & regs.pub_channel_mask)) &&
               (node.value_kind != KIND_UNSUPP);

  always_comb begin
    frame.frame_id         = {PRIO_FIELD, PUB_BITS, node.node_id, regs.device_id};
    frame.payload          = '0;
    frame.payload_len      = LEN_BOOL;
    frame.exponent_invalid = 1'b0;
    case (node.value_kind)
      KIND_FLOAT32: begin
        frame.payload     = {CODE_FLOAT, node.value_bits, 24'd0};
        frame.payload_len = LEN_WORD;
      end
      KIND_INT32: begin
        if (node.exponent == 8'sd0) begin
          frame.payload     = {(neg ? CODE_NEGINT : CODE_POSINT), mag, 24'd0};
          frame.payload_len = LEN_WORD;
        end else begin
          frame.payload = {CODE_DECFRAC, ARRAY_TWO, exp_byte,
                           (neg ? NEG_U32_HDR : POS_U32_HDR), mag};
          frame.payload_len      = LEN_FRAC;
          frame.exponent_invalid = exp_bad;
        end
      end
      KIND_BOOL: begin
        frame.payload     = {(node.value_bits[0] ? CODE_TRUE : CODE_FALSE), 56'd0};
        frame.payload_len = LEN_BOOL;
      end
      default: ;
    endcase
  end

endmodule

### rtl/can_publication_frame_encoder.sv
// Channel  Role  Word                                             Accepted when
// -------  ----  -----------------------------------------------  ------------------
// cfg      sink  index, data (register write)                     cfg.valid (ready=1)
// node     sink  node_id, node_channels, value_kind, exponent,    node.valid & ready
//                value_bits
// frame    src   frame_id, payload, payload_len, exponent_invalid frame.valid & ready
//
// One node word per cycle, sustained while frame.ready holds. A word waits
// in the input register and then moves into the output register through
// the single encode stage between the two registers.
// Reset (rst, synchronous) empties both registers and clears the config.
// A stalled frame holds in the output register; the input register keeps
// filling and only stalls node when both registers are full.
module can_publication_frame_encoder (
  input  logic       clk,
  input  logic       rst,
  cpfe_cfg_if.sink   cfg,
  cpfe_node_if.sink  node,
  cpfe_frame_if.source frame
);
  import cpfe_pkg::*;

  cfg_t   regs;
  node_t  stage;
  logic   stage_valid;
  logic   stage_adv;
  logic   hit;
  frame_t enc;
  frame_t result;
  logic   result_valid;

  cpfe_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Input stage moves on whenever the output register is free or draining
  assign stage_adv  = !result_valid || frame.ready;
  assign node.ready = !stage_valid || stage_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (node.ready) begin
      stage_valid <= node.valid;
    end
  end

  // Capture the node word; payload needs no reset
  always_ff @(posedge clk) begin
    if (node.valid && node.ready) begin
      stage.node_id       <= node.node_id;
      stage.node_channels <= node.node_channels;
      stage.value_kind    <= kind_t'(node.value_kind);
      stage.exponent      <= node.exponent;
      stage.value_bits    <= node.value_bits;
    end
  end

  cpfe_encode u_encode (
    .node  (stage),
    .regs  (regs),
    .hit   (hit),
    .frame (enc)
  );

  // Output register: load a frame on a hit, drop a miss, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_adv) begin
      result_valid <= stage_valid && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && stage_valid && hit) begin
      result <= enc;
    end
  end

  assign frame.valid            = result_valid;
  assign frame.frame_id         = result.frame_id;
  assign frame.payload          = result.payload;
  assign frame.payload_len      = result.payload_len;
  assign frame.exponent_invalid = result.exponent_invalid;

  // Nothing leaves the block right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !frame.valid)
    else $error("frame valid after reset");

  // Every frame carries priority 6 and both publication bits
  a_frame_id_head: assert property (@(posedge clk) disable iff (rst)
    frame.valid |-> frame.frame_id[28:24] == {PRIO_FIELD, PUB_BITS})
    else $error("frame id head wrong");

  // Only the three layouts exist
  a_len_legal: assert property (@(posedge clk) disable iff (rst)
    frame.valid |-> (frame.payload_len == LEN_BOOL || frame.payload_len == LEN_WORD ||
                     frame.payload_len == LEN_FRAC))
    else $error("illegal payload length");

  // A bad exponent only comes with a decimal fraction, exponent byte zeroed
  a_exp_flag: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.exponent_invalid) |->
      (frame.payload_len == LEN_FRAC && frame.payload[47:40] == 8'd0))
    else $error("exponent flag outside decimal fraction");

  // A held input word is not lost while the output stalls
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !stage_adv) |=> stage_valid && $stable(stage))
    else $error("input register changed while stalled");

endmodule
